FILE: rtl/indexed_list_store_top_defines.svh
// Assertion macros shared by the list store RTL.
// Expects clk and rst in the scope where a macro is used.
`ifndef INDEXED_LIST_STORE_TOP_DEFINES_SVH
`define INDEXED_LIST_STORE_TOP_DEFINES_SVH

// Checked only out of reset.
`define ILS_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked on every edge, reset included.
`define ILS_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: rtl/ils_pkg.sv
// Package for the indexed list store: field widths, codes, FSM states and
// the command/status structs between controller and datapath. No dependencies.
package ils_pkg;

  localparam int DEPTH_DEF         = 64;
  localparam int ELEMENT_WIDTH_DEF = 32;

  localparam int OP_W     = 3;
  localparam int POS_W    = 7;
  localparam int DATA_W   = 32;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 7;

  typedef enum logic [OP_W-1:0] {
    OP_PUSH   = 3'd0,
    OP_POP    = 3'd1,
    OP_INSERT = 3'd2,
    OP_REMOVE = 3'd3,
    OP_SET    = 3'd4,
    OP_GET    = 3'd5,
    OP_CLEAR  = 3'd6
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_EMPTY = 2'd2,
    ST_FULL  = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_READ,
    S_LOOP,
    S_SH_WR,
    S_RESULT
  } state_t;

  typedef enum logic [2:0] {
    AS_COUNT,
    AS_COUNT_M1,
    AS_POS,
    AS_CUR,
    AS_CUR_P1,
    AS_CUR_M1
  } addr_sel_t;

  typedef enum logic [1:0] {
    CNT_HOLD,
    CNT_INC,
    CNT_DEC,
    CNT_CLR
  } cnt_op_t;

  typedef enum logic [2:0] {
    CUR_HOLD,
    CUR_LOAD_CNT,
    CUR_LOAD_POS,
    CUR_INC,
    CUR_DEC
  } cur_op_t;

  typedef struct packed {
    logic      load_item;
    logic      latch_status;
    logic      rd_en;
    addr_sel_t rd_sel;
    logic      wr_en;
    addr_sel_t wr_sel;
    logic      wr_from_rdata;
    cnt_op_t   cnt_op;
    cur_op_t   cur_op;
    logic      cap_rd;
    logic      load_out;
  } ctl_cmd_t;

  typedef struct packed {
    op_t  op;
    logic err;
    logic more;
  } dp_stat_t;

endpackage

FILE: rtl/ils_if.sv
// Request and response channel interfaces for the list store.
// Depends on ils_pkg for the field widths.
interface ils_req_if;
  logic                      valid;
  logic                      ready;
  logic [ils_pkg::OP_W-1:0]   op;
  logic [ils_pkg::POS_W-1:0]  position;
  logic [ils_pkg::DATA_W-1:0] data_in;

  modport source (output valid, op, position, data_in, input ready);
  modport sink   (input valid, op, position, data_in, output ready);
endinterface

interface ils_rsp_if;
  logic                        valid;
  logic                        ready;
  logic [ils_pkg::DATA_W-1:0]   data_out;
  logic [ils_pkg::STATUS_W-1:0] status;
  logic [ils_pkg::COUNT_W-1:0]  count_now;
  logic                        is_empty;

  modport source (output valid, data_out, status, count_now, is_empty, input ready);
  modport sink   (input valid, data_out, status, count_now, is_empty, output ready);
endinterface

FILE: rtl/indexed_list_store_top.sv
// Indexed list store top level: controller FSM plus datapath over a one-port-
// write, one-port-read element memory with registered read data.
// Push, set, clear, op 7 and any failed word go from execute to result; pop
// and get add a read state. Insert at p moves count - p elements, remove at p
// moves count - 1 - p after its read, each with a memory read and a write.
// Synchronous reset empties the list; element contents are left as they are.
module indexed_list_store_top #(
  parameter int DEPTH         = ils_pkg::DEPTH_DEF,
  parameter int ELEMENT_WIDTH = ils_pkg::ELEMENT_WIDTH_DEF
) (
  input logic      clk,
  input logic      rst,
  ils_req_if.sink  req,
  ils_rsp_if.source rsp
);

  ils_pkg::ctl_cmd_t cmd;
  ils_pkg::dp_stat_t stat;

  ils_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  ils_dp #(
    .DEPTH         (DEPTH),
    .ELEMENT_WIDTH (ELEMENT_WIDTH)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .op        (req.op),
    .position  (req.position),
    .data_in   (req.data_in),
    .cmd       (cmd),
    .stat      (stat),
    .data_out  (rsp.data_out),
    .status    (rsp.status),
    .count_now (rsp.count_now),
    .is_empty  (rsp.is_empty)
  );

endmodule

FILE: rtl/ils_ctrl.sv
// Controller FSM for the list store: sequences each word's memory accesses
// and the element shift loop. Depends on ils_pkg and the assertion macros.
`include "indexed_list_store_top_defines.svh"

module ils_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  output logic              req_ready,
  output logic              rsp_valid,
  input  logic              rsp_ready,
  input  ils_pkg::dp_stat_t stat,
  output ils_pkg::ctl_cmd_t cmd
);

  ils_pkg::state_t state, state_next;
  logic            out_free;

  assign out_free = !rsp_valid || rsp_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ils_pkg::S_IDLE;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.load_out) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ils_pkg::S_IDLE: begin
        if (req_valid) state_next = ils_pkg::S_EXEC;
      end
      ils_pkg::S_EXEC: begin
        if (stat.err) begin
          state_next = ils_pkg::S_RESULT;
        end else begin
          case (stat.op)
            ils_pkg::OP_POP, ils_pkg::OP_GET, ils_pkg::OP_REMOVE:
              state_next = ils_pkg::S_READ;
            ils_pkg::OP_INSERT: state_next = ils_pkg::S_LOOP;
            default:            state_next = ils_pkg::S_RESULT;
          endcase
        end
      end
      ils_pkg::S_READ: begin
        state_next = (stat.op == ils_pkg::OP_REMOVE) ? ils_pkg::S_LOOP : ils_pkg::S_RESULT;
      end
      ils_pkg::S_LOOP: begin
        state_next = stat.more ? ils_pkg::S_SH_WR : ils_pkg::S_RESULT;
      end
      ils_pkg::S_SH_WR: begin
        state_next = ils_pkg::S_LOOP;
      end
      ils_pkg::S_RESULT: begin
        if (out_free) state_next = ils_pkg::S_IDLE;
      end
      default: state_next = ils_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    req_ready         = 1'b0;
    cmd               = '0;
    cmd.rd_sel        = ils_pkg::AS_POS;
    cmd.wr_sel        = ils_pkg::AS_POS;
    cmd.cnt_op        = ils_pkg::CNT_HOLD;
    cmd.cur_op        = ils_pkg::CUR_HOLD;
    unique case (state)
      ils_pkg::S_IDLE: begin
        req_ready     = 1'b1;
        cmd.load_item = req_valid;
      end
      ils_pkg::S_EXEC: begin
        cmd.latch_status = 1'b1;
        if (!stat.err) begin
          case (stat.op)
            ils_pkg::OP_PUSH: begin
              cmd.wr_en  = 1'b1;
              cmd.wr_sel = ils_pkg::AS_COUNT;
              cmd.cnt_op = ils_pkg::CNT_INC;
            end
            ils_pkg::OP_POP: begin
              cmd.rd_en  = 1'b1;
              cmd.rd_sel = ils_pkg::AS_COUNT_M1;
              cmd.cnt_op = ils_pkg::CNT_DEC;
            end
            ils_pkg::OP_INSERT: begin
              cmd.cur_op = ils_pkg::CUR_LOAD_CNT;
            end
            ils_pkg::OP_REMOVE: begin
              cmd.rd_en  = 1'b1;
              cmd.cur_op = ils_pkg::CUR_LOAD_POS;
            end
            ils_pkg::OP_SET: begin
              cmd.wr_en = 1'b1;
            end
            ils_pkg::OP_GET: begin
              cmd.rd_en = 1'b1;
            end
            ils_pkg::OP_CLEAR: begin
              cmd.cnt_op = ils_pkg::CNT_CLR;
            end
            default: ;
          endcase
        end
      end
      ils_pkg::S_READ: begin
        cmd.cap_rd = 1'b1;
      end
      ils_pkg::S_LOOP: begin
        if (stat.more) begin
          cmd.rd_en  = 1'b1;
          cmd.rd_sel = (stat.op == ils_pkg::OP_INSERT) ? ils_pkg::AS_CUR_M1
                                                       : ils_pkg::AS_CUR_P1;
        end else if (stat.op == ils_pkg::OP_INSERT) begin
          // gap is open at position: drop the new element in
          cmd.wr_en  = 1'b1;
          cmd.cnt_op = ils_pkg::CNT_INC;
        end else begin
          cmd.cnt_op = ils_pkg::CNT_DEC;
        end
      end
      ils_pkg::S_SH_WR: begin
        cmd.wr_en         = 1'b1;
        cmd.wr_sel        = ils_pkg::AS_CUR;
        cmd.wr_from_rdata = 1'b1;
        cmd.cur_op        = (stat.op == ils_pkg::OP_INSERT) ? ils_pkg::CUR_DEC
                                                            : ils_pkg::CUR_INC;
      end
      ils_pkg::S_RESULT: begin
        cmd.load_out = out_free;
      end
      default: ;
    endcase
  end

  `ILS_ASSERT(a_accept_to_exec, ((req_valid && req_ready) |=> (state == ils_pkg::S_EXEC)), "accepted word not executed")
  `ILS_ASSERT(a_load_out_free, (cmd.load_out |-> (!rsp_valid || rsp_ready)), "result overwrites pending word")
  `ILS_ASSERT(a_shift_after_loop, ((state == ils_pkg::S_SH_WR) |-> ($past(state) == ils_pkg::S_LOOP)), "shift write without read")

endmodule

FILE: rtl/ils_dp.sv
// Datapath for the list store: item registers, element memory, fill count,
// shift cursor and result register. Depends on ils_pkg and the assertion macros.
`include "indexed_list_store_top_defines.svh"

module ils_dp #(
  parameter int DEPTH         = ils_pkg::DEPTH_DEF,
  parameter int ELEMENT_WIDTH = ils_pkg::ELEMENT_WIDTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic [ils_pkg::OP_W-1:0]     op,
  input  logic [ils_pkg::POS_W-1:0]    position,
  input  logic [ils_pkg::DATA_W-1:0]   data_in,
  input  ils_pkg::ctl_cmd_t            cmd,
  output ils_pkg::dp_stat_t            stat,
  output logic [ils_pkg::DATA_W-1:0]   data_out,
  output logic [ils_pkg::STATUS_W-1:0] status,
  output logic [ils_pkg::COUNT_W-1:0]  count_now,
  output logic                         is_empty
);

  localparam int AW    = $clog2(DEPTH);
  localparam int CW    = $clog2(DEPTH + 1);
  localparam int CMPW  = (CW > ils_pkg::POS_W) ? CW : ils_pkg::POS_W;
  localparam int CNTX  = (CW > ils_pkg::COUNT_W) ? CW : ils_pkg::COUNT_W;
  localparam int WIDE  = (ELEMENT_WIDTH > ils_pkg::DATA_W) ? ELEMENT_WIDTH : ils_pkg::DATA_W;

  logic [ELEMENT_WIDTH-1:0] mem [DEPTH];

  ils_pkg::op_t             op_q;
  logic [ils_pkg::POS_W-1:0] pos_q;
  logic [ELEMENT_WIDTH-1:0] val_q;
  logic [CW-1:0]            count;
  logic [CW-1:0]            cursor;
  logic [ELEMENT_WIDTH-1:0] rdata;
  logic [ELEMENT_WIDTH-1:0] rd_hold;
  ils_pkg::status_t         status_q;
  ils_pkg::status_t         err_code;

  logic [WIDE-1:0]          in_wide;
  logic [WIDE-1:0]          rd_wide;
  logic [CMPW-1:0]          pos_wide;
  logic [CMPW-1:0]          cnt_cmp;
  logic [CMPW-1:0]          cur_cmp;
  logic [CNTX-1:0]          cnt_wide;
  logic [CW-1:0]            cnt_m1;
  logic [CW-1:0]            cur_p1;
  logic [CW-1:0]            cur_m1;
  logic                     full;
  logic [AW-1:0]            rd_addr;
  logic [AW-1:0]            wr_addr;
  logic [ELEMENT_WIDTH-1:0] wr_data;

  assign in_wide  = WIDE'(data_in);
  assign rd_wide  = WIDE'(rd_hold);
  assign pos_wide = CMPW'(pos_q);
  assign cnt_cmp  = CMPW'(count);
  assign cur_cmp  = CMPW'(cursor);
  assign cnt_wide = CNTX'(count);
  assign cnt_m1   = count - CW'(1);
  assign cur_p1   = cursor + CW'(1);
  assign cur_m1   = cursor - CW'(1);
  assign full     = (count == CW'(DEPTH));

  function automatic logic [AW-1:0] addr_of(input ils_pkg::addr_sel_t sel,
                                            input logic [CW-1:0] cnt,
                                            input logic [CW-1:0] cm1,
                                            input logic [CMPW-1:0] p,
                                            input logic [CW-1:0] c,
                                            input logic [CW-1:0] cp1,
                                            input logic [CW-1:0] cn1);
    logic [AW-1:0] a;
    unique case (sel)
      ils_pkg::AS_COUNT:    a = cnt[AW-1:0];
      ils_pkg::AS_COUNT_M1: a = cm1[AW-1:0];
      ils_pkg::AS_POS:      a = p[AW-1:0];
      ils_pkg::AS_CUR:      a = c[AW-1:0];
      ils_pkg::AS_CUR_P1:   a = cp1[AW-1:0];
      ils_pkg::AS_CUR_M1:   a = cn1[AW-1:0];
      default:              a = '0;
    endcase
    return a;
  endfunction

  assign rd_addr = addr_of(cmd.rd_sel, count, cnt_m1, pos_wide, cursor, cur_p1, cur_m1);
  assign wr_addr = addr_of(cmd.wr_sel, count, cnt_m1, pos_wide, cursor, cur_p1, cur_m1);
  assign wr_data = cmd.wr_from_rdata ? rdata : val_q;

  // Status check on the latched word, against the count before it changes.
  always_comb begin
    err_code = ils_pkg::ST_OK;
    case (op_q)
      ils_pkg::OP_PUSH: begin
        if (full) err_code = ils_pkg::ST_FULL;
      end
      ils_pkg::OP_POP: begin
        if (count == '0) err_code = ils_pkg::ST_EMPTY;
      end
      ils_pkg::OP_INSERT: begin
        if (pos_wide > cnt_cmp) err_code = ils_pkg::ST_RANGE;
        else if (full)          err_code = ils_pkg::ST_FULL;
      end
      ils_pkg::OP_REMOVE, ils_pkg::OP_SET, ils_pkg::OP_GET: begin
        if (pos_wide >= cnt_cmp) err_code = ils_pkg::ST_RANGE;
      end
      default: err_code = ils_pkg::ST_OK;
    endcase
  end

  assign stat.op   = op_q;
  assign stat.err  = (err_code != ils_pkg::ST_OK);
  // insert walks down from the tail, remove walks up towards it
  assign stat.more = (op_q == ils_pkg::OP_INSERT) ? (cur_cmp > pos_wide) : (cur_p1 < count);

  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_en) begin
      rdata <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      unique case (cmd.cnt_op)
        ils_pkg::CNT_HOLD: count <= count;
        ils_pkg::CNT_INC:  count <= count + CW'(1);
        ils_pkg::CNT_DEC:  count <= cnt_m1;
        ils_pkg::CNT_CLR:  count <= '0;
        default:           count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      op_q    <= ils_pkg::op_t'(op);
      pos_q   <= position;
      val_q   <= in_wide[ELEMENT_WIDTH-1:0];
      rd_hold <= '0;
    end else if (cmd.cap_rd) begin
      rd_hold <= rdata;
    end
    if (cmd.latch_status) begin
      status_q <= err_code;
    end
    unique case (cmd.cur_op)
      ils_pkg::CUR_HOLD:     cursor <= cursor;
      ils_pkg::CUR_LOAD_CNT: cursor <= count;
      ils_pkg::CUR_LOAD_POS: cursor <= pos_wide[CW-1:0];
      ils_pkg::CUR_INC:      cursor <= cur_p1;
      ils_pkg::CUR_DEC:      cursor <= cur_m1;
      default:               cursor <= cursor;
    endcase
    if (cmd.load_out) begin
      data_out  <= rd_wide[ils_pkg::DATA_W-1:0];
      status    <= status_q;
      count_now <= cnt_wide[ils_pkg::COUNT_W-1:0];
      is_empty  <= (count == '0);
    end
  end

  `ILS_ASSERT(a_count_bound, (count <= CW'(DEPTH)), "fill count beyond capacity")
  `ILS_ASSERT(a_err_keeps_count, ((cmd.latch_status && stat.err) |=> $stable(count)), "failed word changed the count")

endmodule

FILE: tb/ils_list_checker.sv
// Watch-only checker for the indexed list store: keeps its own copy of the list,
// predicts each reply word and compares it with what the block returns.
// Depends on ils_pkg and the ils_req_if / ils_rsp_if channel interfaces.
module ils_list_checker (
  input  logic clk,
  input  logic rst,
  ils_req_if   req,
  ils_rsp_if   rsp,
  output int   fail_count,
  output int   pending
);
  timeunit 1ns;
  timeprecision 1ps;

  import ils_pkg::*;

  localparam int LIST_DEPTH = DEPTH_DEF;
  localparam int REPORT_MAX = 10;

  typedef struct packed {
    logic [DATA_W-1:0]  data;
    status_t            status;
    logic [COUNT_W-1:0] count;
    logic               empty;
  } list_reply_t;

  logic [DATA_W-1:0] elems [LIST_DEPTH];
  int                list_len = 0;
  int                fails = 0;
  list_reply_t       reply_q [$];

  // One list operation on the shadow copy; errors leave the copy untouched.
  function automatic list_reply_t apply_list_op(logic [OP_W-1:0] opc, logic [POS_W-1:0] pos,
                                                logic [DATA_W-1:0] val);
    list_reply_t r;
    int          i;
    r.data   = '0;
    r.status = ST_OK;
    case (opc)
      OP_PUSH: begin
        if (list_len >= LIST_DEPTH) begin
          r.status = ST_FULL;
        end else begin
          elems[list_len] = val;
          list_len++;
        end
      end
      OP_POP: begin
        if (list_len == 0) begin
          r.status = ST_EMPTY;
        end else begin
          list_len--;
          r.data = elems[list_len];
        end
      end
      OP_INSERT: begin
        // index check takes priority over the full check
        if (int'(pos) > list_len) begin
          r.status = ST_RANGE;
        end else if (list_len >= LIST_DEPTH) begin
          r.status = ST_FULL;
        end else begin
          for (i = list_len; i > int'(pos); i--) elems[i] = elems[i-1];
          elems[pos] = val;
          list_len++;
        end
      end
      OP_REMOVE: begin
        if (int'(pos) >= list_len) begin
          r.status = ST_RANGE;
        end else begin
          r.data = elems[pos];
          for (i = int'(pos); i + 1 < list_len; i++) elems[i] = elems[i+1];
          list_len--;
        end
      end
      OP_SET: begin
        if (int'(pos) >= list_len) r.status = ST_RANGE;
        else elems[pos] = val;
      end
      OP_GET: begin
        if (int'(pos) >= list_len) r.status = ST_RANGE;
        else r.data = elems[pos];
      end
      OP_CLEAR: list_len = 0;
      default: ;
    endcase
    r.count = list_len[COUNT_W-1:0];
    r.empty = (list_len == 0);
    return r;
  endfunction

  always @(posedge clk) begin
    list_reply_t got;
    list_reply_t want;
    if (rst) begin
      list_len = 0;
      reply_q.delete();
    end else begin
      if (rsp.valid && rsp.ready) begin
        got.data   = rsp.data_out;
        got.status = status_t'(rsp.status);
        got.count  = rsp.count_now;
        got.empty  = rsp.is_empty;
        if (reply_q.size() == 0) begin
          fails++;
          if (fails <= REPORT_MAX)
            $display("%0t: reply word with none outstanding: data %h st %0d cnt %0d empty %b",
                     $realtime, got.data, got.status, got.count, got.empty);
        end else begin
          want = reply_q.pop_front();
          if (got.data !== want.data || got.status !== want.status ||
              got.count !== want.count || got.empty !== want.empty) begin
            fails++;
            if (fails <= REPORT_MAX)
              $display("%0t: reply mismatch: exp data %h st %0d cnt %0d empty %b, got data %h st %0d cnt %0d empty %b",
                       $realtime, want.data, want.status, want.count, want.empty,
                       got.data, got.status, got.count, got.empty);
          end
        end
      end
      if (req.valid && req.ready)
        reply_q.push_back(apply_list_op(req.op, req.position, req.data_in));
    end
    pending    <= reply_q.size();
    fail_count <= fails;
  end

endmodule

FILE: tb/tb_indexed_list_store_top.sv
// Testbench top for indexed_list_store_top: clock, reset, request words and
// reply back-pressure; checking is left to ils_list_checker.
// Depends on ils_pkg, ils_if.sv, the block and tb/ils_list_checker.sv.
module tb_indexed_list_store_top;
  timeunit 1ns;
  timeprecision 1ps;

  import ils_pkg::*;

  localparam int              LIST_DEPTH  = DEPTH_DEF;
  localparam int              RANDOM_OPS  = 1150;
  localparam int              SETTLE_CYC  = 200;
  localparam logic [OP_W-1:0] OP_UNUSED   = 3'd7;

  typedef enum {GROW, SHRINK, CHURN} drift_t;

  logic clk;
  logic rst;
  int   fail_count;
  int   pending;
  int   tx_idle_pct = 36;
  int   rx_idle_pct = 81;
  int   list_len = 0;      // tracked only to aim positions and steer the mix
  drift_t drift = GROW;
  int   churn_left = 0;

  ils_req_if req_ch ();
  ils_rsp_if rsp_ch ();

  indexed_list_store_top dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  ils_list_checker checker_i (
    .clk        (clk),
    .rst        (rst),
    .req        (req_ch),
    .rsp        (rsp_ch),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  always @(negedge clk) begin
    rsp_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
  end

  initial begin
    #10_000_000;
    $display("FAILURE");
    $finish;
  end

  task automatic track_len(logic [OP_W-1:0] opc, logic [POS_W-1:0] pos);
    case (opc)
      OP_PUSH:   if (list_len < LIST_DEPTH) list_len++;
      OP_POP:    if (list_len > 0) list_len--;
      OP_INSERT: if (int'(pos) <= list_len && list_len < LIST_DEPTH) list_len++;
      OP_REMOVE: if (int'(pos) < list_len) list_len--;
      OP_CLEAR:  list_len = 0;
      default: ;
    endcase
  endtask

  // Drive one request word from the falling edge and hold it until accepted.
  task automatic send_word(logic [OP_W-1:0] opc, logic [POS_W-1:0] pos,
                           logic [DATA_W-1:0] val);
    @(negedge clk);
    while ($urandom_range(99) < tx_idle_pct) begin
      req_ch.valid <= 1'b0;
      @(negedge clk);
    end
    req_ch.valid    <= 1'b1;
    req_ch.op       <= opc;
    req_ch.position <= pos;
    req_ch.data_in  <= val;
    do @(posedge clk); while (!req_ch.ready);
    track_len(opc, pos);
  endtask

  task automatic send_random_word();
    int                roll;
    int                pick;
    logic [OP_W-1:0]   opc;
    logic [POS_W-1:0]  pos;
    logic [DATA_W-1:0] val;
    roll = $urandom_range(99);
    case (drift)
      GROW:
        opc = roll < 45 ? OP_PUSH : roll < 80 ? OP_INSERT : roll < 85 ? OP_POP :
              roll < 90 ? OP_REMOVE : roll < 95 ? OP_SET : OP_GET;
      SHRINK:
        opc = roll < 40 ? OP_POP : roll < 75 ? OP_REMOVE : roll < 80 ? OP_PUSH :
              roll < 85 ? OP_INSERT : roll < 90 ? OP_SET : roll < 95 ? OP_GET :
              roll < 97 ? OP_CLEAR : OP_UNUSED;
      default: opc = OP_W'($urandom_range(7));
    endcase
    pick = $urandom_range(99);
    if (pick < 10) pos = POS_W'($urandom_range(127));
    else if (pick < 18) pos = POS_W'(list_len);     // boundary: one past the last
    else if (opc == OP_INSERT) pos = POS_W'($urandom_range(list_len, 0));
    else if (list_len > 0) pos = POS_W'($urandom_range(list_len - 1, 0));
    else pos = '0;
    pick = $urandom_range(99);
    val = pick < 5 ? '0 : pick < 10 ? '1 : $urandom;
    send_word(opc, pos, val);
    // steer between filling to full, draining to empty and short mixed runs
    case (drift)
      GROW: begin
        if (list_len == LIST_DEPTH && $urandom_range(9) == 0) begin
          if ($urandom_range(1) == 0) begin
            drift = SHRINK;
          end else begin
            drift = CHURN;
            churn_left = $urandom_range(60, 20);
          end
        end
      end
      SHRINK: if (list_len == 0 && $urandom_range(5) == 0) drift = GROW;
      default: begin
        churn_left--;
        if (churn_left <= 0) drift = GROW;
      end
    endcase
  endtask

  initial begin
    rst             = 1'b1;
    req_ch.valid    = 1'b0;
    req_ch.op       = '0;
    req_ch.position = '0;
    req_ch.data_in  = '0;
    rsp_ch.ready    = 1'b0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // errors on the empty list
    send_word(OP_GET, 7'd0, 32'h0);
    send_word(OP_POP, 7'd0, 32'h0);
    send_word(OP_REMOVE, 7'd0, 32'h0);
    send_word(OP_SET, 7'd0, 32'h1);
    send_word(OP_INSERT, 7'd1, 32'h2);
    // build a short list: front insert, append by insert, middle insert
    send_word(OP_PUSH, 7'd0, 32'hFFFF_FFFF);
    send_word(OP_INSERT, 7'd0, 32'h0);
    send_word(OP_INSERT, 7'd2, 32'h1234_5678);
    send_word(OP_INSERT, 7'd1, 32'hA5A5_A5A5);
    send_word(OP_PUSH, 7'd0, 32'h5A5A_5A5A);
    for (int p = 0; p <= 5; p++) send_word(OP_GET, POS_W'(p), 32'h0);
    send_word(OP_SET, 7'd4, 32'hDEAD_BEEF);
    send_word(OP_REMOVE, 7'd1, 32'h0);
    send_word(OP_REMOVE, 7'd3, 32'h0);
    send_word(OP_POP, 7'd0, 32'h0);
    send_word(OP_GET, 7'd127, 32'hFFFF_FFFF);
    send_word(OP_UNUSED, 7'd127, 32'hFFFF_FFFF);
    send_word(OP_CLEAR, 7'd0, 32'h0);
    send_word(OP_POP, 7'd0, 32'h0);
    send_word(OP_PUSH, 7'd0, 32'h1);

    for (int k = 0; k < RANDOM_OPS; k++) begin
      if (k < RANDOM_OPS / 3) begin
        tx_idle_pct = 36;
        rx_idle_pct = 81;
      end else if (k < 2 * RANDOM_OPS / 3) begin
        tx_idle_pct = 81;
        rx_idle_pct = 36;
      end else begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end
      send_random_word();
    end
    @(negedge clk);
    req_ch.valid <= 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYC) @(posedge clk);
    if (fail_count == 0 && pending == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule
